// ===== design/olad_pkg.sv =====
// Shared types and constants for the ordered list block.
`default_nettype none
package olad_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    // wide enough for any list length in the supported depth range
    localparam int LEN_W     = 6;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SHOW   = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        K_APPENDED = 3'd0,
        K_FULL     = 3'd1,
        K_DELETED  = 3'd2,
        K_NOTFOUND = 3'd3,
        K_ENTRY    = 3'd4,
        K_EMPTY    = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_LOAD = 2'd1,
        OP_ROT  = 2'd2,
        OP_DROP = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [LEN_W-1:0]  tail;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SEARCH = 2'd1,
        ST_REPORT = 2'd2,
        ST_SHOW   = 2'd3
    } state_t;

endpackage
`default_nettype wire

// ===== design/ordered_list_append_delete.sv =====
// Ordered list with append, delete-first-match and show, held in a rotating chain of cells.
// Append: the result beat appears in the output register in the cycle after the command is accepted.
// Show: one entry beat per cycle, paced by m_axis_tready; an empty list gives a single empty beat.
// Delete: a search pass rotating the chain once, one report beat, then, only if a match was
//   deleted, a show pass over the remaining entries; when exhausted, a single empty beat.
// One command at a time; s_axis_tready is high only between commands.
// rst_n (async, active low) empties the list and clears the exhausted flag.
`default_nettype none
module ordered_list_append_delete #(
    parameter int DEPTH = olad_pkg::DEPTH_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [31:0] value
    input  wire  [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] entry_value
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = olad_pkg::DATA_W;

    olad_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       step_reg, step_next;
    logic [CW-1:0]       bound_reg, bound_next;
    logic                found_reg, found_next;
    logic                exh_reg, exh_next;
    logic [DW-1:0]       key_reg, key_next;

    logic                ov_reg, ov_next;
    olad_pkg::kind_t     kind_reg, kind_next;
    logic [DW-1:0]       odata_reg, odata_next;
    logic                olast_reg, olast_next;

    olad_pkg::cell_ctl_t ctl;
    logic                load_out;
    logic                out_free;
    logic                in_acc;
    logic [DW-1:0]       cv [DEPTH];
    logic [DW-1:0]       head;
    olad_pkg::cmd_t      cmd;

    assign head     = cv[0];
    assign out_free = !ov_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == olad_pkg::ST_IDLE) && out_free;
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign cmd      = olad_pkg::cmd_t'(s_axis_tuser);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            olad_cell #(
                .IDX(gi)
            ) u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .wdata    (s_axis_tdata),
                .head     (head),
                .next_val (cv[(gi + 1) % DEPTH]),
                .val      (cv[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            olad_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (cmd)
                        olad_pkg::CMD_DELETE:
                            state_next = exh_reg ? olad_pkg::ST_IDLE : olad_pkg::ST_SEARCH;
                        olad_pkg::CMD_SHOW:
                            state_next = olad_pkg::ST_SHOW;
                        default:
                            state_next = olad_pkg::ST_IDLE;
                    endcase
                end
            end
            olad_pkg::ST_SEARCH:
            begin
                if (step_reg == bound_reg)
                    state_next = olad_pkg::ST_REPORT;
            end
            olad_pkg::ST_REPORT:
            begin
                if (out_free)
                    state_next = found_reg ? olad_pkg::ST_SHOW : olad_pkg::ST_IDLE;
            end
            olad_pkg::ST_SHOW:
            begin
                if (out_free && ((count_reg == '0) || (step_reg == count_reg - CW'(1))))
                    state_next = olad_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = olad_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl.op     = olad_pkg::OP_HOLD;
        ctl.tail   = '0;
        load_out   = 1'b0;
        kind_next  = kind_reg;
        odata_next = '0;
        olast_next = 1'b1;
        count_next = count_reg;
        step_next  = step_reg;
        bound_next = bound_reg;
        found_next = found_reg;
        exh_next   = exh_reg;
        key_next   = key_reg;
        case (state_reg)
            olad_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    key_next   = s_axis_tdata;
                    step_next  = '0;
                    found_next = 1'b0;
                    bound_next = count_reg;
                    case (cmd)
                        olad_pkg::CMD_APPEND:
                        begin
                            load_out = 1'b1;
                            if (count_reg == CW'(DEPTH))
                                kind_next = olad_pkg::K_FULL;
                            else
                            begin
                                kind_next  = olad_pkg::K_APPENDED;
                                ctl.op     = olad_pkg::OP_LOAD;
                                ctl.tail   = olad_pkg::LEN_W'(count_reg);
                                count_next = count_reg + CW'(1);
                                exh_next   = 1'b0;
                            end
                        end
                        olad_pkg::CMD_DELETE:
                        begin
                            if (exh_reg)
                            begin
                                load_out  = 1'b1;
                                kind_next = olad_pkg::K_EMPTY;
                            end
                        end
                        default:
                        begin
                            load_out = 1'b0;
                        end
                    endcase
                end
            end
            olad_pkg::ST_SEARCH:
            begin
                if (step_reg != bound_reg)
                begin
                    step_next = step_reg + CW'(1);
                    if (!found_reg && (head == key_reg))
                    begin
                        ctl.op     = olad_pkg::OP_DROP;
                        count_next = count_reg - CW'(1);
                        found_next = 1'b1;
                    end
                    else
                    begin
                        ctl.op   = olad_pkg::OP_ROT;
                        ctl.tail = olad_pkg::LEN_W'(count_reg - CW'(1));
                    end
                end
            end
            olad_pkg::ST_REPORT:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (found_reg)
                    begin
                        kind_next  = olad_pkg::K_DELETED;
                        odata_next = key_reg;
                        olast_next = 1'b0;
                        step_next  = '0;
                        exh_next   = (count_reg == '0);
                    end
                    else
                        kind_next = olad_pkg::K_NOTFOUND;
                end
            end
            olad_pkg::ST_SHOW:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (count_reg == '0)
                        kind_next = olad_pkg::K_EMPTY;
                    else
                    begin
                        ctl.op     = olad_pkg::OP_ROT;
                        ctl.tail   = olad_pkg::LEN_W'(count_reg - CW'(1));
                        kind_next  = olad_pkg::K_ENTRY;
                        odata_next = head;
                        olast_next = (step_reg == count_reg - CW'(1));
                        step_next  = step_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    assign ov_next = load_out ? 1'b1 : (m_axis_tready ? 1'b0 : ov_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= olad_pkg::ST_IDLE;
            count_reg <= '0;
            step_reg  <= '0;
            bound_reg <= '0;
            found_reg <= 1'b0;
            exh_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            bound_reg <= bound_next;
            found_reg <= found_next;
            exh_reg   <= exh_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (load_out)
        begin
            kind_reg  <= kind_next;
            odata_reg <= odata_next;
            olast_reg <= olast_next;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tlast  = olast_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("list count beyond depth");

    a_exh_empty: assert property (@(posedge clk) disable iff (!rst_n)
        exh_reg |-> (count_reg == '0))
        else $error("exhausted flag with entries present");

    a_search_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == olad_pkg::ST_SEARCH) |=> (count_reg <= $past(count_reg)))
        else $error("count grew during search");

    a_deleted_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && (kind_reg == olad_pkg::K_DELETED)) |-> !olast_reg)
        else $error("deleted beat marked last");

endmodule
`default_nettype wire

// ===== design/olad_cell.sv =====
// One storage cell of the list chain.
`default_nettype none
module olad_cell #(
    parameter int IDX = 0
) (
    input  wire                          clk,
    input  wire olad_pkg::cell_ctl_t     ctl,
    input  wire  [olad_pkg::DATA_W-1:0]  wdata,
    input  wire  [olad_pkg::DATA_W-1:0]  head,
    input  wire  [olad_pkg::DATA_W-1:0]  next_val,
    output logic [olad_pkg::DATA_W-1:0]  val
);

    localparam logic [olad_pkg::LEN_W-1:0] IDX_L = olad_pkg::LEN_W'(IDX);

    logic [olad_pkg::DATA_W-1:0] val_reg;
    logic [olad_pkg::DATA_W-1:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        case (ctl.op)
            olad_pkg::OP_LOAD:
            begin
                if (IDX_L == ctl.tail)
                    val_next = wdata;
            end
            olad_pkg::OP_ROT:
            begin
                if (IDX_L < ctl.tail)
                    val_next = next_val;
                else if (IDX_L == ctl.tail)
                    val_next = head;
            end
            olad_pkg::OP_DROP:
            begin
                val_next = next_val;
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule
`default_nettype wire
